// ----- design/msps_pkg.sv -----
package msps_pkg;

    localparam int LINES_W    = 6;
    localparam int CH_W       = 3;
    localparam int GAP_W      = 8;
    localparam int POS_W      = 15;
    localparam int LEN_W      = 16;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CH_W-1:0]  COUNT_RST = 3'd0;
    localparam logic [GAP_W-1:0] GAP_RST   = 8'd7;
    localparam logic [POS_W-1:0] BASE_RST  = 15'd16000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_GAP_MS        = 2'd1,
        CFG_PULSE_BASE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_FINE_TICK  = 2'd0,
        REQ_FRAME_TICK = 2'd1,
        REQ_POS_WRITE  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        PH_GAP   = 2'b01,
        PH_PULSE = 2'b10
    } t_phase;

    typedef struct packed {
        logic [CH_W-1:0]  channel_count;
        logic [GAP_W-1:0] gap_ms;
        logic [POS_W-1:0] pulse_base;
    } t_cfg;

    typedef struct packed {
        logic [LINES_W-1:0] servo_lines;
        logic [CH_W-1:0]    active_channel;
        logic               in_gap;
    } t_result;

endpackage

// ----- design/msps_if.sv -----
interface msps_in_if import msps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CH_W-1:0]   channel;
    logic [POS_W-1:0]  position;

    modport source (output valid, req_type, channel, position, input ready);
    modport sink   (input valid, req_type, channel, position, output ready);
endinterface

interface msps_out_if import msps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LINES_W-1:0] servo_lines;
    logic [CH_W-1:0]    active_channel;
    logic               in_gap;

    modport source (output valid, servo_lines, active_channel, in_gap, input ready);
    modport sink   (input valid, servo_lines, active_channel, in_gap, output ready);
endinterface

interface msps_cfg_if import msps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/msps_cfg_regs.sv -----
module msps_cfg_regs import msps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msps_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= COUNT_RST;
            r_cfg.gap_ms        <= GAP_RST;
            r_cfg.pulse_base    <= BASE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg.data[CH_W-1:0];
                CFG_GAP_MS:        r_cfg.gap_ms        <= i_cfg.data[GAP_W-1:0];
                CFG_PULSE_BASE:    r_cfg.pulse_base    <= i_cfg.data[POS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- design/msps_step.sv -----
module msps_step import msps_pkg::*; #(
    parameter int MAX_CHANNELS    = 6,
    parameter int CENTER_POSITION = 8000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_fire,
    input  logic [REQ_W-1:0] i_req,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [POS_W-1:0] i_position,
    output t_result          o_result
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CH_W:0]    MAX_CH   = (CH_W + 1)'(MAX_CHANNELS);
    localparam logic [POS_W-1:0] POS_RST  = POS_W'(CENTER_POSITION);

    t_phase           r_phase, n_phase;
    logic [CH_W-1:0]  r_cur, n_cur;
    logic [GAP_W-1:0] r_gap, n_gap;
    logic [LEN_W-1:0] r_pcnt, n_pcnt;
    logic [LEN_W-1:0] r_len, n_len;
    logic [POS_W-1:0] r_pos [MAX_CHANNELS];

    logic [CH_W:0]    w_count;
    logic [CH_W:0]    w_next_ch;
    logic [CH_W-1:0]  w_start_ch;
    logic [POS_W-1:0] w_rd_pos;
    logic [LEN_W-1:0] w_len;
    logic [7:0]       w_onehot;

    // a count above the channel limit behaves as the limit
    assign w_count = ({1'b0, i_cfg.channel_count} > MAX_CH) ? MAX_CH
                                                            : {1'b0, i_cfg.channel_count};
    assign w_next_ch  = {1'b0, r_cur} + (CH_W + 1)'(1);
    // in the gap the only pulse that can start is channel zero
    assign w_start_ch = (r_phase == PH_GAP) ? '0 : w_next_ch[CH_W-1:0];
    assign w_rd_pos   = ({1'b0, w_start_ch} < MAX_CH) ? r_pos[w_start_ch[IDX_W-1:0]] : '0;
    assign w_len      = LEN_W'(i_cfg.pulse_base) + LEN_W'(w_rd_pos);

    always_comb begin
        n_phase = r_phase;
        n_cur   = r_cur;
        n_gap   = r_gap;
        n_pcnt  = r_pcnt;
        n_len   = r_len;
        if (w_count == '0) begin
            n_phase = PH_GAP;
            n_cur   = '0;
            n_gap   = '0;
            n_pcnt  = '0;
        end
        unique case (i_req)
            REQ_FRAME_TICK: begin
                if (w_count != '0 && r_phase == PH_GAP) begin
                    n_gap = r_gap + GAP_W'(1);
                    if (n_gap >= i_cfg.gap_ms) begin
                        n_gap   = '0;
                        n_phase = PH_PULSE;
                        n_cur   = w_start_ch;
                        n_pcnt  = '0;
                        n_len   = w_len;
                    end
                end
            end
            REQ_FINE_TICK: begin
                if (w_count != '0 && r_phase == PH_PULSE) begin
                    n_pcnt = r_pcnt + LEN_W'(1);
                    if (n_pcnt >= r_len) begin
                        if (w_next_ch >= w_count) begin
                            n_phase = PH_GAP;
                            n_cur   = '0;
                            n_gap   = '0;
                            n_pcnt  = '0;
                        end else begin
                            n_phase = PH_PULSE;
                            n_cur   = w_start_ch;
                            n_pcnt  = '0;
                            n_len   = w_len;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign w_onehot = 8'd1 << n_cur;

    always_comb begin
        o_result.in_gap         = (n_phase == PH_GAP);
        o_result.servo_lines    = (n_phase == PH_PULSE) ? w_onehot[LINES_W-1:0] : '0;
        o_result.active_channel = (n_phase == PH_PULSE) ? n_cur : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GAP;
            r_cur   <= '0;
            r_gap   <= '0;
            r_pcnt  <= '0;
            r_len   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_gap   <= n_gap;
            r_pcnt  <= n_pcnt;
            r_len   <= n_len;
        end
    end

    // position store, reset to centre; writes beyond the channel limit are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_pos[i] <= POS_RST;
            end
        end else if (i_fire && i_req == REQ_POS_WRITE && {1'b0, i_channel} < MAX_CH) begin
            r_pos[i_channel[IDX_W-1:0]] <= i_position;
        end
    end

endmodule

// ----- design/multi_servo_pulse_sequencer_unit.sv -----
// Servo pulse sequencer. Each request (fine tick, frame tick or position write) gives
// exactly one result showing the lines, running channel and gap flag after that request.
// One request is taken every clock cycle while the output is not stalled: a request
// is held in the input register, and when it moves on the sequencer state and the
// result register update together. The rate is set by the phase, counters and
// latched length updating alongside the result register. Results wait in the
// output register while new requests keep coming in; a stalled output stops input
// only once both registers are full. Configuration writes are taken every cycle and
// must only be made while no request is in flight.
module multi_servo_pulse_sequencer_unit import msps_pkg::*; #(
    parameter int MAX_CHANNELS    = 6,
    parameter int CENTER_POSITION = 8000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msps_in_if.sink     i_in,
    msps_out_if.source  o_out,
    msps_cfg_if.sink    i_cfg
);

    t_cfg             w_cfg;
    t_result          w_result;
    t_result          r_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic [REQ_W-1:0] r_req;
    logic [CH_W-1:0]  r_ch;
    logic [POS_W-1:0] r_pos;
    logic             w_adv;

    msps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    msps_step #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .CENTER_POSITION (CENTER_POSITION)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_fire     (w_adv),
        .i_req      (r_req),
        .i_channel  (r_ch),
        .i_position (r_pos),
        .o_result   (w_result)
    );

    // request moves on when the output register is free or being emptied
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req <= i_in.req_type;
            r_ch  <= i_in.channel;
            r_pos <= i_in.position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.servo_lines    = r_result.servo_lines;
    assign o_out.active_channel = r_result.active_channel;
    assign o_out.in_gap         = r_result.in_gap;

    a_lines_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot0(o_out.servo_lines))
        else $error("more than one servo line high");

    a_gap_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.in_gap) |->
            (o_out.servo_lines == '0 && o_out.active_channel == '0))
        else $error("line or channel active during gap");

    a_line_matches_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.in_gap && o_out.active_channel < CH_W'(LINES_W)) |->
            (o_out.servo_lines == (LINES_W'(1) << o_out.active_channel)))
        else $error("servo line does not match running channel");

    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_adv) && w_cfg.channel_count == '0 && $stable(w_cfg)) |->
            r_result.in_gap)
        else $error("pulse running with output disabled");

endmodule
